[rtl/sfla_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared types, codes and helpers of the segregated free-list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

  typedef logic [31:0] addr_t;
  typedef logic [63:0] word_t;

  localparam int HEAP_BYTES_DEF  = 65536;
  localparam int NUM_LISTS_DEF   = 20;
  localparam int CHUNK_BYTES_DEF = 4096;

  localparam addr_t MIN_BLOCK = 32'd32;
  localparam addr_t TAG_MASK  = ~32'hF;
  localparam word_t ALLOC_BIT = 64'h1;

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_NOOP = 2'd2;

  // size field of a boundary tag
  function automatic addr_t tag_size(word_t w);
    return w[31:0] & TAG_MASK;
  endfunction

  // floor(log2(size)) capped at max_idx, 0 for sizes 0 and 1
  function automatic logic [4:0] class_of(addr_t s, logic [4:0] max_idx);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 1; i < 32; i++) begin
      if (s[i]) p = i[4:0];
    end
    if (p > max_idx) p = max_idx;
    return p;
  endfunction

endpackage

[rtl/sfla_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfla_ram
// Single-port heap word memory with a registered read port.
// ----------------------------------------------------------------------------
module sfla_ram #(
  parameter int WORDS = sfla_pkg::HEAP_BYTES_DEF / 8
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(WORDS)-1:0] addr,
  input  sfla_pkg::word_t          wdata,
  output sfla_pkg::word_t          rdata
);

  sfla_pkg::word_t mem [WORDS];

  // write or read one word per cycle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[rtl/segregated_free_list_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segregated_free_list_allocator
// Boundary-tag heap allocator with segregated LIFO free lists.
// ----------------------------------------------------------------------------
// One request at a time: busy is high from acceptance until the cycle in
// which done pulses with the result; a new start may be given in that cycle.
// Block tags and list links live in one single-port word memory, one access
// per cycle, while the list heads and the break are registers; the time a
// request takes follows its memory accesses: an allocation takes longer for
// each free-list node visited and when the heap must grow, and trivial
// requests answer without raising busy. The receiver cannot stall: take the result while done is high.
// No clearing pass follows reset.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator #(
  parameter int HEAP_BYTES  = sfla_pkg::HEAP_BYTES_DEF,
  parameter int NUM_LISTS   = sfla_pkg::NUM_LISTS_DEF,
  parameter int CHUNK_BYTES = sfla_pkg::CHUNK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [15:0] req_size,
  input  logic [15:0] free_addr,
  output logic        done,
  output logic [15:0] result_addr,
  output logic [1:0]  status
);

  localparam int WORDS      = HEAP_BYTES / 8;
  localparam int IW         = $clog2(WORDS);
  localparam int LW         = $clog2(NUM_LISTS);
  localparam int WALK_LIMIT = HEAP_BYTES / 32 + 1;
  localparam int SW         = $clog2(WALK_LIMIT + 1);
  localparam sfla_pkg::addr_t CHUNK_R = 32'((CHUNK_BYTES + 15) / 16 * 16);
  localparam logic [4:0]      MAX_CLS = 5'(NUM_LISTS - 1);
  localparam logic [32:0]     HEAP_LIM = 33'(HEAP_BYTES);

  typedef enum logic [5:0] {
    S_IDLE, S_BUILD, S_BUILD_W2, S_BUILD_DONE,
    S_GROW, S_GROW_WH, S_GROW_WF, S_GROW_WE,
    S_FF_HEAD, S_FF_TEST, S_FF_CHK, S_FF_NXT, S_FF_MISS,
    S_TAKE, S_TAKE_RD, S_TAKE_SZ, S_TAKE_WH, S_TAKE_WF,
    S_SPL_WH, S_SPL_WF, S_SPL_RH, S_SPL_RF, S_ALLOC_OK,
    S_REL_RD, S_REL_CHK, S_REL_RF, S_REL_FT, S_REL_WH, S_REL_WF, S_REL_OK,
    S_MG0, S_MG1, S_MG2, S_MG3, S_MG4, S_MG5, S_MG_RMN, S_MG_PUT, S_MG_PUTF,
    S_RM0, S_RM1, S_RM2, S_RM3, S_RM4, S_RM5, S_RM6, S_RM7,
    S_INS0, S_INS1, S_INS2, S_INS3, S_INS4
  } state_t;

  state_t state, ret_mg, ret_rm, ret_ins;

  sfla_pkg::addr_t heads [NUM_LISTS];
  sfla_pkg::addr_t heap_break;
  logic            started;

  sfla_pkg::addr_t blk, sz, asize, gn, cur, pblk, nblk, psz, nsz;
  sfla_pkg::addr_t rb, lp, ln, ib, ihead;
  logic [15:0]     rsize;
  logic [LW-1:0]   idx, rcls, icls, hsel;
  logic [SW-1:0]   steps;
  logic            pu, nu, rd_ok;

  // memory port
  logic            mem_rd, mem_wr, in_rng;
  sfla_pkg::addr_t mem_a;
  sfla_pkg::word_t mem_wd, ram_q, rd;

  sfla_pkg::addr_t asize_in, rd_sz, pfs, hval;
  logic            build_fits, grow_fits, split_ok, rel_bad;

  assign busy = (state != S_IDLE);

  assign asize_in = (32'(req_size) + 32'd31) & sfla_pkg::TAG_MASK;
  assign rd       = rd_ok ? ram_q : '0;
  assign rd_sz    = sfla_pkg::tag_size(rd);
  assign pfs      = rd_sz;
  assign hsel     = (state == S_INS2) ? icls : idx;
  assign hval     = heads[hsel];

  assign build_fits = ({1'b0, heap_break} + 33'd16) <= HEAP_LIM;
  assign grow_fits  = ({1'b0, heap_break} + {1'b0, gn}) <= HEAP_LIM;
  assign split_ok   = (sz >= asize) && ((sz - asize) >= sfla_pkg::MIN_BLOCK);
  assign rel_bad    = (rd_sz < sfla_pkg::MIN_BLOCK)
                   || (rd != {32'd0, rd_sz | 32'd1})
                   || (({1'b0, blk} + {1'b0, rd_sz} + 33'd8) > {1'b0, heap_break});

  // drive the memory access of the current step
  always_comb begin
    mem_rd = 1'b0;
    mem_wr = 1'b0;
    mem_a  = '0;
    mem_wd = '0;
    case (state)
      S_BUILD:    begin mem_wr = build_fits; mem_a = heap_break; mem_wd = 64'd1; end
      S_BUILD_W2: begin mem_wr = 1'b1; mem_a = heap_break + 32'd8; mem_wd = 64'd1; end
      S_GROW_WH:  begin mem_wr = 1'b1; mem_a = blk; mem_wd = {32'd0, sz}; end
      S_GROW_WF:  begin mem_wr = 1'b1; mem_a = blk + sz - 32'd8; mem_wd = {32'd0, sz}; end
      S_GROW_WE:  begin mem_wr = 1'b1; mem_a = blk + sz; mem_wd = 64'd1; end
      S_FF_TEST:  begin
        mem_rd = (cur != '0) && (steps < SW'(WALK_LIMIT));
        mem_a  = cur;
      end
      S_FF_CHK:   begin mem_rd = (rd_sz < asize); mem_a = cur + 32'd16; end
      S_TAKE_RD:  begin mem_rd = 1'b1; mem_a = blk; end
      S_TAKE_WH:  begin mem_wr = 1'b1; mem_a = blk; mem_wd = {32'd0, sz} | sfla_pkg::ALLOC_BIT; end
      S_TAKE_WF:  begin
        mem_wr = 1'b1; mem_a = blk + sz - 32'd8; mem_wd = {32'd0, sz} | sfla_pkg::ALLOC_BIT;
      end
      S_SPL_WH:   begin
        mem_wr = 1'b1; mem_a = blk; mem_wd = {32'd0, asize} | sfla_pkg::ALLOC_BIT;
      end
      S_SPL_WF:   begin
        mem_wr = 1'b1; mem_a = blk + asize - 32'd8;
        mem_wd = {32'd0, asize} | sfla_pkg::ALLOC_BIT;
      end
      S_SPL_RH:   begin mem_wr = 1'b1; mem_a = blk + asize; mem_wd = {32'd0, sz - asize}; end
      S_SPL_RF:   begin
        mem_wr = 1'b1; mem_a = blk + sz - 32'd8; mem_wd = {32'd0, sz - asize};
      end
      S_REL_RD:   begin mem_rd = 1'b1; mem_a = blk; end
      S_REL_RF:   begin mem_rd = 1'b1; mem_a = blk + sz - 32'd8; end
      S_REL_WH:   begin mem_wr = 1'b1; mem_a = blk; mem_wd = {32'd0, sz}; end
      S_REL_WF:   begin mem_wr = 1'b1; mem_a = blk + sz - 32'd8; mem_wd = {32'd0, sz}; end
      S_MG0:      begin mem_rd = 1'b1; mem_a = blk - 32'd8; end
      S_MG1:      begin mem_rd = 1'b1; mem_a = blk; end
      S_MG2:      begin mem_rd = 1'b1; mem_a = pblk; end
      S_MG3:      begin mem_rd = 1'b1; mem_a = nblk; end
      S_MG_PUT:   begin mem_wr = 1'b1; mem_a = blk; mem_wd = {32'd0, sz}; end
      S_MG_PUTF:  begin mem_wr = 1'b1; mem_a = blk + sz - 32'd8; mem_wd = {32'd0, sz}; end
      S_RM0:      begin mem_rd = 1'b1; mem_a = rb; end
      S_RM1:      begin mem_rd = 1'b1; mem_a = rb + 32'd8; end
      S_RM2:      begin mem_rd = 1'b1; mem_a = rb + 32'd16; end
      S_RM4:      begin mem_wr = (lp != '0); mem_a = lp + 32'd16; mem_wd = {32'd0, ln}; end
      S_RM5:      begin mem_wr = (ln != '0); mem_a = ln + 32'd8; mem_wd = {32'd0, lp}; end
      S_RM6:      begin mem_wr = 1'b1; mem_a = rb + 32'd8; end
      S_RM7:      begin mem_wr = 1'b1; mem_a = rb + 32'd16; end
      S_INS0:     begin mem_rd = 1'b1; mem_a = ib; end
      S_INS2:     begin mem_wr = 1'b1; mem_a = ib + 32'd16; mem_wd = {32'd0, hval}; end
      S_INS3:     begin mem_wr = 1'b1; mem_a = ib + 32'd8; end
      S_INS4:     begin mem_wr = (ihead != '0); mem_a = ihead + 32'd8; mem_wd = {32'd0, ib}; end
      default:    begin mem_rd = 1'b0; end
    endcase
  end

  // drop accesses outside the heap
  assign in_rng = (mem_a < 32'(HEAP_BYTES));

  sfla_ram #(.WORDS(WORDS)) u_ram (
    .clk   (clk),
    .en    ((mem_rd || mem_wr) && in_rng),
    .we    (mem_wr),
    .addr  (mem_a[IW+2:3]),
    .wdata (mem_wd),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    rd_ok <= in_rng;
  end

  // sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      heap_break <= '0;
      started    <= 1'b0;
      done       <= 1'b0;
      for (int i = 0; i < NUM_LISTS; i++) heads[i] <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            result_addr <= '0;
            if (req_type == sfla_pkg::REQ_ALLOC) begin
              rsize <= req_size;
              asize <= asize_in;
              idx   <= LW'(sfla_pkg::class_of(asize_in, MAX_CLS));
              if (!started) begin
                state <= S_BUILD;
              end else if (req_size == '0) begin
                done <= 1'b1; status <= sfla_pkg::ST_NOOP;
              end else begin
                state <= S_FF_HEAD;
              end
            end else if (free_addr == '0 || !started || free_addr[3:0] != 4'd0) begin
              done <= 1'b1; status <= sfla_pkg::ST_NOOP;
            end else begin
              blk   <= 32'(free_addr) - 32'd8;
              state <= S_REL_RD;
            end
          end
        end
        // lazy heap build
        S_BUILD: begin
          if (!build_fits) begin
            done <= 1'b1; status <= sfla_pkg::ST_OOM; state <= S_IDLE;
          end else begin
            state <= S_BUILD_W2;
          end
        end
        S_BUILD_W2: begin
          heap_break <= heap_break + 32'd16;
          started    <= 1'b1;
          gn         <= CHUNK_R;
          ret_mg     <= S_BUILD_DONE;
          state      <= S_GROW;
        end
        S_BUILD_DONE: begin
          if (rsize == '0) begin
            done <= 1'b1; status <= sfla_pkg::ST_NOOP; state <= S_IDLE;
          end else begin
            state <= S_FF_HEAD;
          end
        end
        // extend the break by gn bytes
        S_GROW: begin
          if (!grow_fits) begin
            done <= 1'b1; status <= sfla_pkg::ST_OOM; state <= S_IDLE;
          end else begin
            blk        <= heap_break - 32'd8;
            sz         <= gn;
            heap_break <= heap_break + gn;
            state      <= S_GROW_WH;
          end
        end
        S_GROW_WH: state <= S_GROW_WF;
        S_GROW_WF: state <= S_GROW_WE;
        S_GROW_WE: state <= S_MG0;
        // first-fit walk over the classes
        S_FF_HEAD: begin
          cur   <= hval;
          steps <= '0;
          state <= S_FF_TEST;
        end
        S_FF_TEST: begin
          if (cur != '0 && steps < SW'(WALK_LIMIT)) begin
            state <= S_FF_CHK;
          end else if (idx == LW'(NUM_LISTS - 1)) begin
            state <= S_FF_MISS;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_FF_HEAD;
          end
        end
        S_FF_CHK: begin
          if (rd_sz >= asize) begin
            blk   <= cur;
            state <= S_TAKE;
          end else begin
            state <= S_FF_NXT;
          end
        end
        S_FF_NXT: begin
          cur   <= rd[31:0];
          steps <= steps + 1'b1;
          state <= S_FF_TEST;
        end
        S_FF_MISS: begin
          gn     <= (asize > CHUNK_R) ? asize : CHUNK_R;
          ret_mg <= S_TAKE;
          state  <= S_GROW;
        end
        // unlink, mark used, split the tail
        S_TAKE: begin
          rb     <= blk;
          ret_rm <= S_TAKE_RD;
          state  <= S_RM0;
        end
        S_TAKE_RD: state <= S_TAKE_SZ;
        S_TAKE_SZ: begin
          sz    <= rd_sz;
          state <= S_TAKE_WH;
        end
        S_TAKE_WH: state <= S_TAKE_WF;
        S_TAKE_WF: state <= split_ok ? S_SPL_WH : S_ALLOC_OK;
        S_SPL_WH:  state <= S_SPL_WF;
        S_SPL_WF:  state <= S_SPL_RH;
        S_SPL_RH:  state <= S_SPL_RF;
        S_SPL_RF: begin
          ib      <= blk + asize;
          ret_ins <= S_ALLOC_OK;
          state   <= S_INS0;
        end
        S_ALLOC_OK: begin
          done        <= 1'b1;
          status      <= sfla_pkg::ST_DONE;
          result_addr <= 16'(blk + 32'd8);
          state       <= S_IDLE;
        end
        // release: check the tags, then mark the block free
        S_REL_RD: state <= S_REL_CHK;
        S_REL_CHK: begin
          if (rel_bad) begin
            done <= 1'b1; status <= sfla_pkg::ST_NOOP; state <= S_IDLE;
          end else begin
            sz    <= rd_sz;
            state <= S_REL_RF;
          end
        end
        S_REL_RF: state <= S_REL_FT;
        S_REL_FT: begin
          if (rd != {32'd0, sz | 32'd1}) begin
            done <= 1'b1; status <= sfla_pkg::ST_NOOP; state <= S_IDLE;
          end else begin
            state <= S_REL_WH;
          end
        end
        S_REL_WH: state <= S_REL_WF;
        S_REL_WF: begin
          ret_mg <= S_REL_OK;
          state  <= S_MG0;
        end
        S_REL_OK: begin
          done <= 1'b1; status <= sfla_pkg::ST_DONE; state <= S_IDLE;
        end
        // coalesce with free neighbors
        S_MG0: state <= S_MG1;
        S_MG1: begin
          pblk  <= (pfs == '0) ? '0 : blk - pfs;
          state <= S_MG2;
        end
        S_MG2: begin
          sz    <= rd_sz;
          nblk  <= blk + rd_sz;
          state <= S_MG3;
        end
        S_MG3: begin
          pu    <= (pblk == '0) || rd[0];
          psz   <= rd_sz;
          state <= S_MG4;
        end
        S_MG4: begin
          nu    <= (rd_sz == '0) || rd[0];
          nsz   <= rd_sz;
          state <= S_MG5;
        end
        S_MG5: begin
          if (!pu && !nu) begin
            sz <= sz + psz + nsz; rb <= pblk; blk <= pblk;
            ret_rm <= S_MG_RMN; state <= S_RM0;
          end else if (!pu) begin
            sz <= sz + psz; rb <= pblk; blk <= pblk;
            ret_rm <= S_MG_PUT; state <= S_RM0;
          end else if (!nu) begin
            sz <= sz + nsz; rb <= nblk;
            ret_rm <= S_MG_PUT; state <= S_RM0;
          end else begin
            state <= S_MG_PUT;
          end
        end
        S_MG_RMN: begin
          rb     <= nblk;
          ret_rm <= S_MG_PUT;
          state  <= S_RM0;
        end
        S_MG_PUT: state <= S_MG_PUTF;
        S_MG_PUTF: begin
          ib      <= blk;
          ret_ins <= ret_mg;
          state   <= S_INS0;
        end
        // unlink rb from its list
        S_RM0: state <= S_RM1;
        S_RM1: begin
          rcls  <= LW'(sfla_pkg::class_of(rd_sz, MAX_CLS));
          state <= S_RM2;
        end
        S_RM2: begin
          lp    <= rd[31:0];
          state <= S_RM3;
        end
        S_RM3: begin
          ln    <= rd[31:0];
          state <= S_RM4;
        end
        S_RM4: begin
          if (lp == '0) heads[rcls] <= ln;
          state <= S_RM5;
        end
        S_RM5: state <= S_RM6;
        S_RM6: state <= S_RM7;
        S_RM7: state <= ret_rm;
        // push ib on its list
        S_INS0: state <= S_INS1;
        S_INS1: begin
          icls  <= LW'(sfla_pkg::class_of(rd_sz, MAX_CLS));
          state <= S_INS2;
        end
        S_INS2: begin
          ihead <= hval;
          state <= S_INS3;
        end
        S_INS3: state <= S_INS4;
        S_INS4: begin
          heads[icls] <= ib;
          state       <= ret_ins;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/sfla_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfla_chk
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sfla_chk (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        req_type,
  input logic [15:0] req_size,
  input logic [15:0] free_addr,
  input logic        done,
  input logic [15:0] result_addr,
  input logic [1:0]  status
);

  // a result never shows while a transaction is still in flight
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");

  // an accepted transaction either finishes at once or raises busy
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done)) else $error("transaction lost");

  // only the three defined status codes appear
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == sfla_pkg::ST_DONE || status == sfla_pkg::ST_OOM
              || status == sfla_pkg::ST_NOOP)) else $error("bad status");

  // failed or no-op transactions return a null address
  a_null: assert property (@(posedge clk) disable iff (rst)
    (done && status != sfla_pkg::ST_DONE) |-> (result_addr == 16'd0))
    else $error("address on failure");

endmodule

bind segregated_free_list_allocator sfla_chk u_sfla_chk (.*);
